// ===== rtl/bls_pkg.sv =====
// Shared types and constants for the Bresenham line stepper.
// Holds coordinate widths, style and mode codes, and the line state struct.
// No dependencies.
package bls_pkg;

    localparam int COORD_BITS = 12;
    localparam int ERR_BITS   = COORD_BITS + 3;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    localparam logic [1:0] STYLE_NORMAL = 2'd0;
    localparam logic [1:0] STYLE_BOLD   = 2'd1;
    localparam logic [1:0] STYLE_DOTTED = 2'd2;

    localparam logic [1:0] STEP_ZERO = 2'b00;
    localparam logic [1:0] STEP_POS  = 2'b01;
    localparam logic [1:0] STEP_NEG  = 2'b11;

    typedef struct packed {
        logic [COORD_BITS-1:0] cur_x;
        logic [COORD_BITS-1:0] cur_y;
        logic [1:0]            step_x;
        logic [1:0]            step_y;
        logic [COORD_BITS-1:0] major_delta;
        logic [COORD_BITS-1:0] minor_delta;
        logic [ERR_BITS-1:0]   error_term;
        logic                  axes_swapped;
        logic [COORD_BITS-1:0] steps_left;
        logic [1:0]            style;
        logic                  line_active;
    } line_state_t;

    typedef struct packed {
        logic plot;
        logic bold;
        logic last;
        logic valid_res;
    } pixel_flags_t;

    // Sign-extend a two-bit step (+1, 0, -1) to coordinate width.
    function automatic logic [COORD_BITS-1:0] step_ext(input logic [1:0] s);
        return {{(COORD_BITS-2){s[1]}}, s};
    endfunction

endpackage

// ===== rtl/bls_setup.sv =====
// Line setup: deltas, step signs, axis swap and initial decision value.
// Also forms the flags of the first pixel. Depends on bls_pkg.
module bls_setup
    import bls_pkg::*;
(
    input  logic [COORD_BITS-1:0] x_start,
    input  logic [COORD_BITS-1:0] y_start,
    input  logic [COORD_BITS-1:0] x_end,
    input  logic [COORD_BITS-1:0] y_end,
    input  logic [1:0]            line_style,
    output line_state_t           state,
    output pixel_flags_t          flags
);

    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]   dx_mag;
    logic [COORD_BITS:0]   dy_mag;
    logic [COORD_BITS-1:0] adx;
    logic [COORD_BITS-1:0] ady;
    logic                  swapped;
    logic [COORD_BITS-1:0] maj;
    logic [COORD_BITS-1:0] mnr;

    always_comb
    begin
        dx = {x_end[COORD_BITS-1], x_end} - {x_start[COORD_BITS-1], x_start};
        dy = {y_end[COORD_BITS-1], y_end} - {y_start[COORD_BITS-1], y_start};
        dx_mag = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
        dy_mag = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
        adx = dx_mag[COORD_BITS-1:0];
        ady = dy_mag[COORD_BITS-1:0];
        swapped = ady > adx;
        maj = swapped ? ady : adx;
        mnr = swapped ? adx : ady;

        state.cur_x        = x_start;
        state.cur_y        = y_start;
        state.step_x       = (dx == '0) ? STEP_ZERO : (dx[COORD_BITS] ? STEP_NEG : STEP_POS);
        state.step_y       = (dy == '0) ? STEP_ZERO : (dy[COORD_BITS] ? STEP_NEG : STEP_POS);
        state.major_delta  = maj;
        state.minor_delta  = mnr;
        state.error_term   = {2'b00, mnr, 1'b0} - {3'b000, maj};
        state.axes_swapped = swapped;
        state.steps_left   = maj;
        state.style        = line_style;
        state.line_active  = maj != '0;

        // First pixel is always drawn.
        flags.plot      = 1'b1;
        flags.bold      = (line_style == STYLE_BOLD) || (line_style == STYLE_DOTTED);
        flags.last      = maj == '0;
        flags.valid_res = 1'b1;
    end

endmodule

// ===== rtl/bls_step.sv =====
// One Bresenham step: advance the major axis, maybe the minor axis,
// update the decision value and pixel flags. Depends on bls_pkg.
module bls_step
    import bls_pkg::*;
(
    input  line_state_t  state,
    output line_state_t  state_next,
    output pixel_flags_t flags
);

    logic                  err_nonneg;
    logic [COORD_BITS-1:0] x_inc;
    logic [COORD_BITS-1:0] y_inc;
    logic [ERR_BITS-1:0]   err_adj;

    always_comb
    begin
        err_nonneg = !state.error_term[ERR_BITS-1];
        x_inc = step_ext(state.step_x);
        y_inc = step_ext(state.step_y);
        err_adj = {2'b00, state.minor_delta, 1'b0}
                - (err_nonneg ? {2'b00, state.major_delta, 1'b0} : '0);

        state_next = state;
        flags.plot      = 1'b0;
        flags.bold      = 1'b0;
        flags.last      = 1'b1;
        flags.valid_res = 1'b0;

        if (state.line_active)
        begin
            if (state.axes_swapped)
            begin
                state_next.cur_y = state.cur_y + y_inc;
                state_next.cur_x = err_nonneg ? state.cur_x + x_inc : state.cur_x;
            end
            else
            begin
                state_next.cur_x = state.cur_x + x_inc;
                state_next.cur_y = err_nonneg ? state.cur_y + y_inc : state.cur_y;
            end
            state_next.error_term  = state.error_term + err_adj;
            state_next.steps_left  = state.steps_left - 1'b1;
            state_next.line_active = state.steps_left != {{(COORD_BITS-1){1'b0}}, 1'b1};

            flags.last      = !state_next.line_active;
            flags.valid_res = 1'b1;
            unique case (state.style)
                STYLE_BOLD:
                begin
                    flags.plot = 1'b1;
                    flags.bold = 1'b1;
                end
                STYLE_DOTTED:
                begin
                    // draw only where x is a multiple of four
                    flags.plot = state_next.cur_x[1:0] == 2'b00;
                    flags.bold = state_next.cur_x[1:0] == 2'b00;
                end
                STYLE_NORMAL:
                begin
                    flags.plot = 1'b1;
                    flags.bold = 1'b0;
                end
                default:
                begin
                    flags.plot = 1'b1;
                    flags.bold = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== rtl/bresenham_line_stepper_top.sv =====
// Top level of the Bresenham line stepper: line state, result register, handshake.
// Depends on bls_pkg, bls_setup and bls_step.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  input   | in        | in_valid/in_stall  | mode, x_start, y_start, x_end, y_end,
//          |           |                    | line_style
//  output  | out       | out_valid/out_stall| pixel_x, pixel_y, plot, bold, last, valid_res
//
// Every transfer in produces exactly one result, loaded into the result register.
// Throughput is one item per cycle when not stalled: setup logic sits between the input ports and the
// line state and result registers, step logic between the line state registers and the
// result register, so a new item is taken every cycle that in_stall is low.
// in_stall rises only while a result waits and out_stall holds it.
// Reset clears the line state (pixel at 0,0, idle) and empties the result register.
module bresenham_line_stepper_top
    import bls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic [COORD_BITS-1:0] x_start,
    input  logic [COORD_BITS-1:0] y_start,
    input  logic [COORD_BITS-1:0] x_end,
    input  logic [COORD_BITS-1:0] y_end,
    input  logic [1:0]            line_style,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  plot,
    output logic                  bold,
    output logic                  last,
    output logic                  valid_res
);

    line_state_t  line_reg;
    line_state_t  line_next;
    line_state_t  setup_state;
    line_state_t  step_state;
    pixel_flags_t setup_flags;
    pixel_flags_t step_flags;
    pixel_flags_t flags_next;
    pixel_flags_t flags_reg;
    logic [COORD_BITS-1:0] pixel_x_reg;
    logic [COORD_BITS-1:0] pixel_y_reg;
    logic         out_valid_reg;
    logic         in_xfer;

    // Hold off input only while the result register is full and blocked.
    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    bls_setup u_setup (
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .line_style (line_style),
        .state      (setup_state),
        .flags      (setup_flags)
    );

    bls_step u_step (
        .state      (line_reg),
        .state_next (step_state),
        .flags      (step_flags)
    );

    // A start item reloads the line, abandoning any line still running.
    always_comb
    begin
        if (mode == MODE_START)
        begin
            line_next  = setup_state;
            flags_next = setup_flags;
        end
        else
        begin
            line_next  = step_state;
            flags_next = step_flags;
        end
    end

    // Line state advances on each input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                line_reg <= line_next;
            end
            if (in_xfer)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on transfer in, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pixel_x_reg <= line_next.cur_x;
            pixel_y_reg <= line_next.cur_y;
            flags_reg   <= flags_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;
    assign plot      = flags_reg.plot;
    assign bold      = flags_reg.bold;
    assign last      = flags_reg.last;
    assign valid_res = flags_reg.valid_res;

endmodule

// ===== rtl/bls_checker.sv =====
// Port-level checks for the Bresenham line stepper, bound to the top level.
// Depends on bls_pkg and bresenham_line_stepper_top.
module bls_checker
    import bls_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  mode,
    input logic [COORD_BITS-1:0] x_start,
    input logic [COORD_BITS-1:0] y_start,
    input logic [COORD_BITS-1:0] x_end,
    input logic [COORD_BITS-1:0] y_end,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  plot,
    input logic                  bold,
    input logic                  last,
    input logic                  valid_res
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Every input transfer shows a result in the next cycle.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("no result after input transfer");

    // Input is held off only by a blocked result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without blocked output");

    // An idle step draws nothing and reports last.
    a_idle_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> last && !plot && !bold)
        else $error("bad flags on idle step");

    // A start with equal endpoints is a one-pixel line.
    a_point_line: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode == MODE_START && x_start == x_end && y_start == y_end
        |=> last && valid_res && plot)
        else $error("single-pixel line not marked last");

endmodule

bind bresenham_line_stepper_top bls_checker u_bls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .plot      (plot),
    .bold      (bold),
    .last      (last),
    .valid_res (valid_res)
);

// ===== tb/tb_top.sv =====
// Self-checking bench for the Bresenham line stepper: directed lines, then random ones.
// Holds its own pixel predictor, a queued driver and a result monitor.
// Depends on bls_pkg and bresenham_line_stepper_top.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bls_pkg::*;

    // One input transfer as queued for the driver.
    typedef struct {
        logic                  mode;
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [1:0]            style;
    } line_cmd_t;

    // One result transfer as the predictor expects it.
    typedef struct {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic                  plot;
        logic                  bold;
        logic                  last;
        logic                  vres;
    } pixel_rec_t;

    localparam int TOTAL_CMDS  = 1650;
    localparam int TAIL_CMDS   = 120;   // final stretch runs with no idling
    localparam int HOLD_CYCLES = 250;   // long output hold-off
    localparam int HOLD_AT     = 1200;  // pending count that triggers it

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  mode = MODE_START;
    logic [COORD_BITS-1:0] x_start = '0;
    logic [COORD_BITS-1:0] y_start = '0;
    logic [COORD_BITS-1:0] x_end = '0;
    logic [COORD_BITS-1:0] y_end = '0;
    logic [1:0]            line_style = STYLE_NORMAL;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  plot;
    logic                  bold;
    logic                  last;
    logic                  valid_res;

    bresenham_line_stepper_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .line_style (line_style),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .plot       (plot),
        .bold       (bold),
        .last       (last),
        .valid_res  (valid_res)
    );

    always #6 clk = ~clk;

    // Commands waiting to be driven, and pixels waiting to come out.
    line_cmd_t  pending_cmds[$];
    pixel_rec_t expected_pixels[$];
    line_cmd_t  on_bus;
    logic       cmd_taken = 1'b0;
    int         fail_count = 0;

    // Idling control: per-side burst counters, and tick counters that re-pick the busy level.
    int   send_gap = 0;
    int   stall_left = 0;
    int   in_idle_pct = 0;
    int   out_idle_pct = 0;
    int   drv_tick = 0;
    int   stall_tick = 0;
    int   hold_left = 0;
    logic hold_used = 1'b0;
    logic tail_phase = 1'b0;

    // Predicted line state: the pen position, step directions, and decision value.
    logic signed [COORD_BITS-1:0] pen_x = '0;
    logic signed [COORD_BITS-1:0] pen_y = '0;
    logic signed [1:0]            dir_x = STEP_ZERO;
    logic signed [1:0]            dir_y = STEP_ZERO;
    logic [COORD_BITS-1:0]        run_major = '0;
    logic [COORD_BITS-1:0]        run_minor = '0;
    logic [COORD_BITS-1:0]        pix_left = '0;
    logic signed [ERR_BITS-1:0]   decision = '0;
    logic                         y_major = 1'b0;
    logic [1:0]                   pen_style = STYLE_NORMAL;
    logic                         drawing = 1'b0;

    // Advance the predicted line by one command and return the pixel it yields.
    function automatic pixel_rec_t trace_pixel(input line_cmd_t c);
        pixel_rec_t r;
        int         dx;
        int         dy;
        int         adx;
        int         ady;
        if (c.mode == MODE_START) begin
            dx = int'($signed(c.x1)) - int'($signed(c.x0));
            dy = int'($signed(c.y1)) - int'($signed(c.y0));
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            dir_x = (dx > 0) ? STEP_POS : ((dx < 0) ? STEP_NEG : STEP_ZERO);
            dir_y = (dy > 0) ? STEP_POS : ((dy < 0) ? STEP_NEG : STEP_ZERO);
            y_major = ady > adx;
            run_major = COORD_BITS'(y_major ? ady : adx);
            run_minor = COORD_BITS'(y_major ? adx : ady);
            decision = ERR_BITS'(2 * int'(run_minor) - int'(run_major));
            pen_x = c.x0;
            pen_y = c.y0;
            pix_left = run_major;
            pen_style = c.style;
            drawing = pix_left != 0;
            // The first pixel is always drawn; bold and dotted both draw it large.
            r.plot = 1'b1;
            r.bold = (pen_style == STYLE_BOLD) || (pen_style == STYLE_DOTTED);
            r.last = !drawing;
            r.vres = 1'b1;
        end else if (!drawing) begin
            // Step with no line running: report the held pixel, nothing drawn.
            r.plot = 1'b0;
            r.bold = 1'b0;
            r.last = 1'b1;
            r.vres = 1'b0;
        end else begin
            if (decision >= 0) begin
                if (y_major)
                    pen_x = pen_x + dir_x;
                else
                    pen_y = pen_y + dir_y;
                decision = decision - ERR_BITS'(2 * int'(run_major));
            end
            if (y_major)
                pen_y = pen_y + dir_y;
            else
                pen_x = pen_x + dir_x;
            decision = decision + ERR_BITS'(2 * int'(run_minor));
            pix_left = pix_left - 1'b1;
            drawing = pix_left != 0;
            r.plot = 1'b1;
            r.bold = 1'b0;
            if (pen_style == STYLE_BOLD) begin
                r.bold = 1'b1;
            end else if (pen_style == STYLE_DOTTED) begin
                r.plot = pen_x[1:0] == 2'b00;
                r.bold = r.plot;
            end
            r.last = !drawing;
            r.vres = 1'b1;
        end
        r.px = pen_x;
        r.py = pen_y;
        return r;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(4095)) - 2048;
    endfunction

    // Offset a coordinate, mirroring the offset if it would leave the range.
    function automatic int reflect_coord(input int base, input int d);
        if (base + d > 2047 || base + d < -2048)
            return base - d;
        return base + d;
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 8;
            2:       return 25;
            default: return 45;
        endcase
    endfunction

    task automatic add_cmd(input logic m, input int x0, input int y0,
                           input int x1, input int y1, input int style);
        line_cmd_t c;
        c.mode = m;
        c.x0 = COORD_BITS'(x0);
        c.y0 = COORD_BITS'(y0);
        c.x1 = COORD_BITS'(x1);
        c.y1 = COORD_BITS'(y1);
        c.style = 2'(style);
        pending_cmds.push_back(c);
    endtask

    // Step commands carry random don't-care coordinates and style.
    task automatic add_steps(input int n);
        for (int i = 0; i < n; i++)
            add_cmd(MODE_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    $urandom_range(3));
    endtask

    // A start with random endpoints, then mostly enough steps to finish the line
    // and run a little past its end; sometimes it is abandoned part way.
    task automatic add_random_line();
        int kind;
        int span;
        int x0;
        int y0;
        int x1;
        int y1;
        int adx;
        int ady;
        int major;
        int n;
        kind = $urandom_range(99);
        x0 = rand_coord();
        y0 = rand_coord();
        if (kind >= 95) begin
            x1 = rand_coord();
            y1 = rand_coord();
        end else begin
            span = (kind < 80) ? 15 : 200;
            x1 = reflect_coord(x0, int'($urandom_range(2 * span)) - span);
            y1 = reflect_coord(y0, int'($urandom_range(2 * span)) - span);
            case ($urandom_range(9))
                0:       y1 = y0;
                1:       x1 = x0;
                2:       y1 = reflect_coord(y0, x1 - x0);
                default: ;
            endcase
        end
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;
        major = (adx > ady) ? adx : ady;
        if (kind >= 95)
            n = $urandom_range(40);
        else if ($urandom_range(9) < 8)
            n = major + int'($urandom_range(2));
        else
            n = $urandom_range(major);
        add_cmd(MODE_START, x0, y0, x1, y1, $urandom_range(3));
        add_steps(n);
    endtask

    task automatic check_field(input string name, input logic signed [COORD_BITS-1:0] want,
                               input logic signed [COORD_BITS-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Stimulus: directed lines first, then random lines mixed with loose commands.
    initial begin
        // Step straight out of reset: idle, held pixel at the origin.
        add_steps(1);
        // Equal endpoints finish at once; the following step finds no line.
        add_cmd(MODE_START, 0, 0, 0, 0, STYLE_NORMAL);
        add_steps(1);
        // Full-range diagonal across the coordinate extremes, dotted.
        add_cmd(MODE_START, -2048, 2047, 2047, -2048, STYLE_DOTTED);
        add_steps(3);
        // Restart while that line is still running; style three acts as normal.
        // Steep line, run one step past its end.
        add_cmd(MODE_START, 0, 0, 3, -5, 3);
        add_steps(6);
        // Horizontal line at the extremes, bold, abandoned after one step.
        add_cmd(MODE_START, 2047, -2048, -2048, -2048, STYLE_BOLD);
        add_steps(1);
        // Shallow line heading left and down, bold, run to the end and past it.
        add_cmd(MODE_START, 5, 5, -2, 1, STYLE_BOLD);
        add_steps(8);
        // Vertical line, abandoned by the random part.
        add_cmd(MODE_START, -7, 4, -7, -1, STYLE_NORMAL);
        add_steps(2);

        while (pending_cmds.size() < TOTAL_CMDS) begin
            if ($urandom_range(9) == 0)
                add_cmd(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), $urandom_range(3));
            else
                add_random_line();
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: everything sent, every pixel back, then a short settling pause.
        wait (pending_cmds.size() == 0 && !in_valid);
        wait (expected_pixels.size() == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // Phase control: flag the tail of the run, and hold the output once for a
    // long stretch so the result register fills and the input backs up.
    always @(posedge clk) begin
        tail_phase <= pending_cmds.size() < TAIL_CMDS;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (rst_n && !hold_used && pending_cmds.size() < HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // Driver: on the falling edge, hold a stalled transfer, otherwise either
    // idle for a burst or put the next queued command on the bus.
    always @(negedge clk) begin : driver
        if (rst_n) begin
            if (drv_tick % 64 == 0)
                in_idle_pct = pick_idle_pct();
            drv_tick++;
            if (!in_valid || cmd_taken) begin
                cmd_taken = 1'b0;
                if (send_gap != 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_cmds.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (!tail_phase && $urandom_range(99) < in_idle_pct) begin
                    send_gap = $urandom_range(16);
                    in_valid <= 1'b0;
                end else begin
                    on_bus = pending_cmds.pop_front();
                    mode <= on_bus.mode;
                    x_start <= on_bus.x0;
                    y_start <= on_bus.y0;
                    x_end <= on_bus.x1;
                    y_end <= on_bus.y1;
                    line_style <= on_bus.style;
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Output back-pressure: the long hold-off wins, then no stalls in the tail, then random stall bursts.
    always @(negedge clk) begin : stall_gen
        if (stall_tick % 64 == 0)
            out_idle_pct = pick_idle_pct();
        stall_tick++;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
        end else if (tail_phase) begin
            out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if ($urandom_range(99) < out_idle_pct) begin
            stall_left = $urandom_range(16);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: on the rising edge, check any output transfer against the oldest
    // expectation, then predict the pixel for any input transfer.
    always @(posedge clk) begin : monitor
        pixel_rec_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_pixels.size() == 0) begin
                    $error("pixel transfer with nothing expected: x=%0d y=%0d",
                           $signed(pixel_x), $signed(pixel_y));
                    fail_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("pixel_x", want.px, pixel_x);
                    check_field("pixel_y", want.py, pixel_y);
                    check_field("plot", want.plot, plot);
                    check_field("bold", want.bold, bold);
                    check_field("last", want.last, last);
                    check_field("valid_res", want.vres, valid_res);
                end
            end
            if (in_valid && !in_stall) begin
                expected_pixels.push_back(trace_pixel(on_bus));
                cmd_taken = 1'b1;
            end
        end
    end

endmodule

// ===== sim.f =====
rtl/bls_pkg.sv
rtl/bls_setup.sv
rtl/bls_step.sv
rtl/bresenham_line_stepper_top.sv
rtl/bls_checker.sv
tb/tb_top.sv
